// File: design/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stream find-and-replace unit.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int WIN_DEPTH   = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;

    localparam int CHAR_W    = 8;
    localparam int STR_W     = 64;
    localparam int LEN_W     = 4;
    localparam int REP_MAX   = 8;
    localparam int REP_IDX_W = 3;
    localparam int SUM_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_CHARS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_CHARS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN   = 2'd3;

    typedef enum logic [1:0] {
        SRC_REP,
        SRC_POP,
        SRC_MARK
    } t_src;

    typedef struct packed {
        logic                 accept;
        logic                 emit;
        t_src                 src;
        logic [REP_IDX_W-1:0] rep_idx;
        logic                 eos;
        logic                 lor;
    } t_dp_cmd;

    typedef struct packed {
        logic             match;
        logic             full;
        logic [LEN_W-1:0] c_new;
        logic [LEN_W-1:0] rep_len;
    } t_dp_status;

endpackage

// File: design/stream_find_and_replace_unit.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace_unit
// Replaces each leftmost, non-overlapping occurrence of a target string in a
// character stream with a replacement string.
// ----------------------------------------------------------------------------
// The output sequencer emits one word per cycle from the output register
// while the output is not stalled, and the next input word is taken in the
// cycle that the final output word of the current one is loaded. A plain
// pass-through character therefore runs at one word per cycle while the
// output is not stalled; a match emits the replacement characters (only the
// bare end marker when the replacement is empty and nothing follows), and a
// last character that completes no match flushes every held character.
// Configuration writes are always ready and are meant to be made while the
// stream is idle; writing the target length discards held characters.
// ----------------------------------------------------------------------------
module stream_find_and_replace_unit import sfr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [STR_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CHAR_W-1:0]    i_in_char,
    input  logic                 i_is_last,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CHAR_W-1:0]    o_out_char,
    output logic                 o_char_valid,
    output logic                 o_end_of_string,
    output logic                 o_last_of_run
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    sfr_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_is_last   (i_is_last),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    sfr_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_char       (i_in_char),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_char      (o_out_char),
        .o_char_valid    (o_char_valid),
        .o_end_of_string (o_end_of_string),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

// File: design/sfr_datapath.sv
// ----------------------------------------------------------------------------
// sfr_datapath
// Configuration registers, character window with insert and shift, target
// compare and the output word register.
// ----------------------------------------------------------------------------
module sfr_datapath import sfr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [STR_W-1:0]     i_cfg_data,
    input  logic [CHAR_W-1:0]    i_in_char,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic [CHAR_W-1:0]    o_out_char,
    output logic                 o_char_valid,
    output logic                 o_end_of_string,
    output logic                 o_last_of_run
);

    logic [STR_W-1:0]  r_target_chars;
    logic [LEN_W-1:0]  r_target_len;
    logic [STR_W-1:0]  r_replace_chars;
    logic [LEN_W-1:0]  r_replace_len;
    logic [CHAR_W-1:0] r_win [WIN_DEPTH];
    logic [LEN_W-1:0]  r_cnt;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_char_valid;
    logic              r_eos;
    logic              r_lor;

    logic [LEN_W-1:0]  tl;
    logic [LEN_W-1:0]  rl;
    logic              pop;
    logic [CHAR_W-1:0] base_win [WIN_DEPTH];
    logic [CHAR_W-1:0] ins_win  [WIN_DEPTH];
    logic [LEN_W-1:0]  base_cnt;
    logic [LEN_W-1:0]  ins_pos;
    logic [LEN_W-1:0]  c_new;
    logic              full;
    logic              match;

    always_comb begin
        if (r_target_len == '0) begin
            tl = LEN_W'(1);
        end else if (r_target_len > LEN_W'(WIN_DEPTH)) begin
            tl = LEN_W'(WIN_DEPTH);
        end else begin
            tl = r_target_len;
        end
        rl = (r_replace_len > LEN_W'(REP_MAX)) ? LEN_W'(REP_MAX) : r_replace_len;

        pop = i_cmd.emit && (i_cmd.src == SRC_POP);
        for (int k = 0; k < WIN_DEPTH; k++) begin
            base_win[k] = r_win[k];
        end
        if (pop) begin
            for (int k = 0; k < WIN_DEPTH - 1; k++) begin
                base_win[k] = r_win[k+1];
            end
        end
        base_cnt = pop ? (r_cnt - LEN_W'(1)) : r_cnt;
        ins_pos  = (base_cnt >= tl) ? '0 : base_cnt;
        for (int k = 0; k < WIN_DEPTH; k++) begin
            ins_win[k] = (ins_pos == LEN_W'(k)) ? i_in_char : base_win[k];
        end
        c_new = ins_pos + LEN_W'(1);
        full  = (c_new == tl);
        match = full;
        for (int k = 0; k < WIN_DEPTH; k++) begin
            if ((LEN_W'(k) < tl) && (ins_win[k] != r_target_chars[CHAR_W*k +: CHAR_W])) begin
                match = 1'b0;
            end
        end
    end

    assign o_status.match   = match;
    assign o_status.full    = full;
    assign o_status.c_new   = c_new;
    assign o_status.rep_len = rl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_chars  <= '0;
            r_target_len    <= LEN_W'(1);
            r_replace_chars <= '0;
            r_replace_len   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TARGET_CHARS:  r_target_chars  <= i_cfg_data;
                REG_TARGET_LEN:    r_target_len    <= i_cfg_data[LEN_W-1:0];
                REG_REPLACE_CHARS: r_replace_chars <= i_cfg_data;
                REG_REPLACE_LEN:   r_replace_len   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // drop held characters when the target length is written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cfg_valid && (i_cfg_index == REG_TARGET_LEN)) begin
            r_cnt <= '0;
        end else if (i_cmd.accept) begin
            r_cnt <= match ? '0 : c_new;
        end else if (pop) begin
            r_cnt <= r_cnt - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_win <= ins_win;
        end else if (pop) begin
            r_win <= base_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            case (i_cmd.src)
                SRC_REP: begin
                    r_out_char   <= r_replace_chars[CHAR_W*i_cmd.rep_idx +: CHAR_W];
                    r_char_valid <= 1'b1;
                end
                SRC_POP: begin
                    r_out_char   <= r_win[0];
                    r_char_valid <= 1'b1;
                end
                default: begin
                    r_out_char   <= '0;
                    r_char_valid <= 1'b0;
                end
            endcase
            r_eos <= i_cmd.eos;
            r_lor <= i_cmd.lor;
        end
    end

    assign o_out_char      = r_out_char;
    assign o_char_valid    = r_char_valid;
    assign o_end_of_string = r_eos;
    assign o_last_of_run   = r_lor;

endmodule

// File: design/sfr_controller.sv
// ----------------------------------------------------------------------------
// sfr_controller
// Sequencer for the output words of each input word: replacement characters,
// window pops and the bare end marker, plus the input and output handshakes.
// ----------------------------------------------------------------------------
module sfr_controller import sfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_is_last,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [LEN_W-1:0]     r_rep_left;
    logic [LEN_W-1:0]     n_rep_left;
    logic [LEN_W-1:0]     r_pop_left;
    logic [LEN_W-1:0]     n_pop_left;
    logic                 r_mark;
    logic                 n_mark;
    logic                 r_last;
    logic                 n_last;
    logic [REP_IDX_W-1:0] r_rep_idx;
    logic [REP_IDX_W-1:0] n_rep_idx;
    logic                 r_out_valid;
    logic                 n_out_valid;

    logic             busy;
    logic             emit;
    logic             accept;
    logic             final_word;
    t_src             src;
    logic [SUM_W-1:0] left_sum;
    logic [LEN_W-1:0] new_rep;
    logic [LEN_W-1:0] new_pop;
    logic             new_mark;

    always_comb begin
        busy     = (r_state == ST_BUSY);
        emit     = busy && (!r_out_valid || !i_out_stall);
        left_sum = SUM_W'(r_rep_left) + SUM_W'(r_pop_left) + SUM_W'(r_mark);
        final_word = (left_sum == SUM_W'(1));
        if (r_rep_left != '0) begin
            src = SRC_REP;
        end else if (r_pop_left != '0) begin
            src = SRC_POP;
        end else begin
            src = SRC_MARK;
        end
        accept = i_in_valid && (!busy || (emit && final_word));

        new_rep = i_status.match ? i_status.rep_len : '0;
        if (i_status.match) begin
            new_pop = '0;
        end else if (i_is_last) begin
            new_pop = i_status.c_new;
        end else begin
            new_pop = i_status.full ? LEN_W'(1) : '0;
        end
        new_mark = i_is_last && (new_rep == '0) && (new_pop == '0);

        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && ((new_rep != '0) || (new_pop != '0) || new_mark)) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (accept) begin
                    n_state = ((new_rep != '0) || (new_pop != '0) || new_mark) ?
                              ST_BUSY : ST_IDLE;
                end else if (emit && final_word) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        n_rep_left = r_rep_left;
        n_pop_left = r_pop_left;
        n_mark     = r_mark;
        n_last     = r_last;
        n_rep_idx  = r_rep_idx;
        if (accept) begin
            n_rep_left = new_rep;
            n_pop_left = new_pop;
            n_mark     = new_mark;
            n_last     = i_is_last;
            n_rep_idx  = '0;
        end else if (emit) begin
            case (src)
                SRC_REP: begin
                    n_rep_left = r_rep_left - LEN_W'(1);
                    n_rep_idx  = r_rep_idx + REP_IDX_W'(1);
                end
                SRC_POP: n_pop_left = r_pop_left - LEN_W'(1);
                default: n_mark = 1'b0;
            endcase
        end

        n_out_valid = emit ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rep_left  <= '0;
            r_pop_left  <= '0;
            r_mark      <= 1'b0;
            r_last      <= 1'b0;
            r_rep_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rep_left  <= n_rep_left;
            r_pop_left  <= n_pop_left;
            r_mark      <= n_mark;
            r_last      <= n_last;
            r_rep_idx   <= n_rep_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall    = busy && !(emit && final_word);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.accept  = accept;
    assign o_cmd.emit    = emit;
    assign o_cmd.src     = src;
    assign o_cmd.rep_idx = r_rep_idx;
    assign o_cmd.eos     = final_word && r_last;
    assign o_cmd.lor     = final_word;

endmodule
